// ===== rtl/wrw_pkg.sv =====
// Shared types and constants for the wildcard route walker.
// Used by the channel interfaces and by every module of the block but wrw_ram.
package wrw_pkg;

    localparam int NODE_W          = 4;
    localparam int SLOT_W          = 5;
    localparam int TOK_W           = 16;
    localparam int FIELDS          = 4;
    localparam int OUT_W           = 2;

    localparam int NODE_COUNT_DEF     = 16;
    localparam int RULES_PER_NODE_DEF = 16;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [1:0] OP_WRITE_RULE = 2'd0;
    localparam logic [1:0] OP_SET_COUNT  = 2'd1;
    localparam logic [1:0] OP_ROUTE      = 2'd2;

    localparam logic [OUT_W-1:0] OUT_DELIVERED  = 2'd0;
    localparam logic [OUT_W-1:0] OUT_CIRCULAR   = 2'd1;
    localparam logic [OUT_W-1:0] OUT_UNROUTABLE = 2'd2;

    // command kinds after front-end classification
    typedef enum logic [1:0] {
        K_RULE,
        K_COUNT,
        K_ROUTE,
        K_REJECT
    } t_kind;

    typedef struct packed {
        t_kind                            kind;
        logic [NODE_W-1:0]                node;
        logic [SLOT_W-1:0]                slot;
        logic [FIELDS-1:0][TOK_W-1:0]     tokens;
        logic [FIELDS-1:0]                wild;
        logic [NODE_W-1:0]                target;
    } t_cmd;

    typedef struct packed {
        logic [NODE_W-1:0]                target;
        logic [FIELDS-1:0]                wild;
        logic [FIELDS-1:0][TOK_W-1:0]     tokens;
    } t_rule;

endpackage

// ===== rtl/wrw_if.sv =====
// Valid/ready channel interfaces for the command input and the route result output.
// Depends on wrw_pkg for field widths.
interface wrw_in_if;
    import wrw_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic [NODE_W-1:0] node;
    logic [SLOT_W-1:0] slot_or_count;
    logic [TOK_W-1:0]  country;
    logic [TOK_W-1:0]  admin_domain;
    logic [TOK_W-1:0]  private_domain;
    logic [TOK_W-1:0]  organization;
    logic              country_any;
    logic              admin_any;
    logic              private_any;
    logic              org_any;
    logic [NODE_W-1:0] target_node;

    modport source (
        output valid, opcode, node, slot_or_count, country, admin_domain,
               private_domain, organization, country_any, admin_any,
               private_any, org_any, target_node,
        input  ready
    );
    modport sink (
        input  valid, opcode, node, slot_or_count, country, admin_domain,
               private_domain, organization, country_any, admin_any,
               private_any, org_any, target_node,
        output ready
    );
endinterface

interface wrw_out_if;
    import wrw_pkg::*;

    logic              valid;
    logic              ready;
    logic [OUT_W-1:0]  outcome;
    logic [NODE_W-1:0] at_node;

    modport source (output valid, outcome, at_node, input ready);
    modport sink   (input valid, outcome, at_node, output ready);
endinterface

// ===== rtl/wrw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wrw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/wrw_front.sv =====
// Front end: takes input transfers, range-checks them and turns them into queue commands.
// Depends on wrw_pkg and the wrw_in_if interface.
module wrw_front #(
    parameter int NODE_COUNT     = 16,
    parameter int RULES_PER_NODE = 16
) (
    wrw_in_if.sink         i_in,
    input  logic           i_q_ready,
    output logic           o_push,
    output wrw_pkg::t_cmd  o_cmd
);
    import wrw_pkg::*;

    logic node_ok;
    logic slot_ok;
    logic tgt_ok;
    logic keep;

    assign node_ok = 32'(i_in.node) < NODE_COUNT;
    assign slot_ok = 32'(i_in.slot_or_count) < RULES_PER_NODE;
    assign tgt_ok  = 32'(i_in.target_node) < NODE_COUNT;

    always_comb begin
        o_cmd.kind   = K_ROUTE;
        o_cmd.node   = i_in.node;
        o_cmd.slot   = i_in.slot_or_count;
        o_cmd.tokens = {i_in.organization, i_in.private_domain,
                        i_in.admin_domain, i_in.country};
        o_cmd.wild   = {i_in.org_any, i_in.private_any, i_in.admin_any, i_in.country_any};
        o_cmd.target = i_in.target_node;
        keep         = 1'b0;
        case (i_in.opcode)
            OP_WRITE_RULE: begin
                o_cmd.kind = K_RULE;
                keep       = node_ok && slot_ok && tgt_ok;
            end
            OP_SET_COUNT: begin
                o_cmd.kind = K_COUNT;
                keep       = node_ok;
                // count saturates at the rule capacity of a node
                if (32'(i_in.slot_or_count) > RULES_PER_NODE) begin
                    o_cmd.slot = SLOT_W'(RULES_PER_NODE);
                end
            end
            OP_ROUTE: begin
                o_cmd.kind = node_ok ? K_ROUTE : K_REJECT;
                keep       = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    // dropped items are still taken off the channel
    assign i_in.ready = i_q_ready;
    assign o_push     = i_in.valid && i_q_ready && keep;
endmodule

// ===== rtl/wrw_fifo.sv =====
// Short command queue between front end and back end.
// Depends on wrw_pkg for the command type and queue depth.
module wrw_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  wrw_pkg::t_cmd  i_cmd,
    output logic           o_ready,
    output logic           o_valid,
    output wrw_pkg::t_cmd  o_cmd,
    input  logic           i_pop
);
    import wrw_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_ready = 32'(r_count) < QUEUE_DEPTH;
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd_ptr];

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> 32'(r_count) != QUEUE_DEPTH)
        else $error("queue pushed while full");
endmodule

// ===== rtl/wrw_back.sv =====
// Back end: executes rule/count writes and walks a message across nodes, one node per cycle.
// Depends on wrw_pkg, wrw_ram and the wrw_out_if interface.
module wrw_back #(
    parameter int NODE_COUNT     = 16,
    parameter int RULES_PER_NODE = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  wrw_pkg::t_cmd  i_q_cmd,
    output logic           o_q_pop,
    wrw_out_if.source      o_out
);
    import wrw_pkg::*;

    localparam int AW = $clog2(NODE_COUNT);
    localparam int CW = $clog2(RULES_PER_NODE + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_EMIT
    } t_state;

    t_state                r_state,       n_state;
    t_cmd                  r_msg,         n_msg;
    logic [NODE_W-1:0]     r_now,         n_now;
    logic [NODE_COUNT-1:0] r_visited,     n_visited;
    logic [NODE_COUNT-1:0] r_total_vld,   n_total_vld;
    logic                  r_cnt_vld,     n_cnt_vld;
    logic [OUT_W-1:0]      r_res_outcome, n_res_outcome;
    logic [NODE_W-1:0]     r_res_node,    n_res_node;
    logic                  r_out_valid,   n_out_valid;
    logic [OUT_W-1:0]      r_out_outcome, n_out_outcome;
    logic [NODE_W-1:0]     r_out_node,    n_out_node;

    logic                      rd_en;
    logic [NODE_W-1:0]         rd_node;
    logic                      rule_we;
    logic                      cnt_we;
    logic [AW-1:0]             head_addr;
    logic [AW-1:0]             now_addr;
    logic [CW-1:0]             cnt_wdata;
    logic [CW+SLOT_W-1:0]      cnt_wide;
    logic [CW-1:0]             cnt_rd;
    logic [CW-1:0]             cnt_eff;
    logic [RULES_PER_NODE-1:0] lane_sel;
    logic [RULES_PER_NODE-1:0] hit;
    logic [RULES_PER_NODE-1:0] first;
    logic                      hit_any;
    logic [NODE_W-1:0]         hit_tgt;
    logic [AW-1:0]             tgt_addr;
    logic                      tgt_oob;
    logic                      tgt_seen;
    logic                      eval_move;
    t_rule                     rule_wdata;
    t_rule                     lane_rd [RULES_PER_NODE];

    function automatic logic [AW-1:0] node_addr(input logic [NODE_W-1:0] n);
        logic [AW+NODE_W-1:0] w;
        w = {{AW{1'b0}}, n};
        return w[AW-1:0];
    endfunction

    assign head_addr = node_addr(i_q_cmd.node);
    assign now_addr  = node_addr(r_now);
    assign cnt_wide  = {{CW{1'b0}}, i_q_cmd.slot};
    assign cnt_wdata = cnt_wide[CW-1:0];

    assign rule_wdata.target = i_q_cmd.target;
    assign rule_wdata.wild   = i_q_cmd.wild;
    assign rule_wdata.tokens = i_q_cmd.tokens;

    // one RAM lane per rule slot, addressed by node, so a node's whole row is read at once
    for (genvar s = 0; s < RULES_PER_NODE; s++) begin : g_lane
        assign lane_sel[s] = 32'(i_q_cmd.slot) == s;

        wrw_ram #(
            .WIDTH ($bits(t_rule)),
            .DEPTH (NODE_COUNT)
        ) u_lane (
            .i_clk   (i_clk),
            .i_we    (rule_we && lane_sel[s]),
            .i_waddr (head_addr),
            .i_wdata (rule_wdata),
            .i_re    (rd_en),
            .i_raddr (node_addr(rd_node)),
            .o_rdata (lane_rd[s])
        );
    end

    wrw_ram #(
        .WIDTH (CW),
        .DEPTH (NODE_COUNT)
    ) u_total (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (head_addr),
        .i_wdata (cnt_wdata),
        .i_re    (rd_en),
        .i_raddr (node_addr(rd_node)),
        .o_rdata (cnt_rd)
    );

    // parallel first-match over the row of the current node
    always_comb begin
        cnt_eff = r_cnt_vld ? cnt_rd : '0;
        for (int s = 0; s < RULES_PER_NODE; s++) begin
            hit[s] = 32'(cnt_eff) > s;
            for (int f = 0; f < FIELDS; f++) begin
                if (!(r_msg.wild[f] || lane_rd[s].wild[f] ||
                      r_msg.tokens[f] == lane_rd[s].tokens[f])) begin
                    hit[s] = 1'b0;
                end
            end
        end
        first   = hit & (~hit + RULES_PER_NODE'(1));
        hit_any = |hit;
        hit_tgt = '0;
        for (int s = 0; s < RULES_PER_NODE; s++) begin
            if (first[s]) begin
                hit_tgt |= lane_rd[s].target;
            end
        end
    end

    assign tgt_addr  = node_addr(hit_tgt);
    assign tgt_oob   = 32'(hit_tgt) >= NODE_COUNT;
    assign tgt_seen  = r_visited[tgt_addr];
    assign eval_move = hit_any && !tgt_oob && hit_tgt != r_now && !tgt_seen;

    always_comb begin
        n_state       = r_state;
        n_msg         = r_msg;
        n_now         = r_now;
        n_visited     = r_visited;
        n_total_vld   = r_total_vld;
        n_cnt_vld     = r_cnt_vld;
        n_res_outcome = r_res_outcome;
        n_res_node    = r_res_node;
        n_out_valid   = r_out_valid;
        n_out_outcome = r_out_outcome;
        n_out_node    = r_out_node;
        rd_en         = 1'b0;
        rd_node       = i_q_cmd.node;
        rule_we       = 1'b0;
        cnt_we        = 1'b0;
        o_q_pop       = 1'b0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    case (i_q_cmd.kind)
                        K_RULE: begin
                            rule_we = 1'b1;
                        end
                        K_COUNT: begin
                            cnt_we                 = 1'b1;
                            n_total_vld[head_addr] = 1'b1;
                        end
                        K_ROUTE: begin
                            rd_en                = 1'b1;
                            n_msg                = i_q_cmd;
                            n_now                = i_q_cmd.node;
                            n_visited            = '0;
                            n_visited[head_addr] = 1'b1;
                            n_cnt_vld            = r_total_vld[head_addr];
                            n_state              = S_EVAL;
                        end
                        K_REJECT: begin
                            n_res_outcome = OUT_UNROUTABLE;
                            n_res_node    = i_q_cmd.node;
                            n_state       = S_EMIT;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_EVAL: begin
                if (eval_move) begin
                    rd_en               = 1'b1;
                    rd_node             = hit_tgt;
                    n_now               = hit_tgt;
                    n_visited[tgt_addr] = 1'b1;
                    n_cnt_vld           = r_total_vld[tgt_addr];
                end else begin
                    n_state    = S_EMIT;
                    n_res_node = r_now;
                    if (!hit_any || tgt_oob) begin
                        n_res_outcome = OUT_UNROUTABLE;
                    end else if (hit_tgt == r_now) begin
                        n_res_outcome = OUT_DELIVERED;
                    end else begin
                        // loop reported at the node seen before
                        n_res_outcome = OUT_CIRCULAR;
                        n_res_node    = hit_tgt;
                    end
                end
            end
            S_EMIT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid   = 1'b1;
                    n_out_outcome = r_res_outcome;
                    n_out_node    = r_res_node;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_visited   <= '0;
            r_total_vld <= '0;
            r_cnt_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_visited   <= n_visited;
            r_total_vld <= n_total_vld;
            r_cnt_vld   <= n_cnt_vld;
            r_out_valid <= n_out_valid;
        end
        r_msg         <= n_msg;
        r_now         <= n_now;
        r_res_outcome <= n_res_outcome;
        r_res_node    <= n_res_node;
        r_out_outcome <= n_out_outcome;
        r_out_node    <= n_out_node;
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.outcome = r_out_outcome;
    assign o_out.at_node = r_out_node;

    a_now_visited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EVAL |-> r_visited[now_addr])
        else $error("current node not marked visited");

    a_hop_marks_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) && eval_move |=>
            $countones(r_visited) == $past($countones(r_visited)) + 1)
        else $error("hop did not mark exactly one new node");

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EMIT))
        else $error("result loaded outside emit state");
endmodule

// ===== rtl/wildcard_route_walk.sv =====
// Top level of the wildcard route walker: front end, command queue and back end.
// Depends on wrw_pkg, wrw_if, wrw_front, wrw_fifo, wrw_back and wrw_ram.
//
// Commands enter on i_in and are range-checked by the front end, which drops
// invalid writes and unused opcodes, then queued (two entries) for the back end.
// A rule write or count write is carried out as it is popped from the queue. A route
// message first reads its start node's rule row, then runs a parallel first-match
// over all rule slots of each node visited, at most NODE_COUNT nodes, and then
// loads the result register; each hop waits on the registered node-row read of
// the rule lane RAMs. The load waits while the previous result is still held on
// o_out. The result register lets the input side keep accepting while a result
// waits on o_out.
// Rule counts reset to zero through per-node valid bits; rule slots need no
// clearing and there is no clearing pass after reset.
module wildcard_route_walk #(
    parameter int NODE_COUNT     = wrw_pkg::NODE_COUNT_DEF,
    parameter int RULES_PER_NODE = wrw_pkg::RULES_PER_NODE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wrw_in_if.sink     i_in,
    wrw_out_if.source  o_out
);
    import wrw_pkg::*;

    logic push;
    t_cmd push_cmd;
    logic q_ready;
    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;

    wrw_front #(
        .NODE_COUNT     (NODE_COUNT),
        .RULES_PER_NODE (RULES_PER_NODE)
    ) u_front (
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_cmd     (push_cmd)
    );

    wrw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    wrw_back #(
        .NODE_COUNT     (NODE_COUNT),
        .RULES_PER_NODE (RULES_PER_NODE)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );
endmodule

// ===== tb/wildcard_route_walk_tb.sv =====
// Self-checking testbench for wildcard_route_walk: rule writes, count writes and routes.
// Each route outcome is predicted and results are checked in order.
// Depends on wrw_pkg, the wrw_in_if/wrw_out_if interfaces and the wildcard_route_walk RTL.
module wildcard_route_walk_tb;
    import wrw_pkg::*;

    localparam int NODES = NODE_COUNT_DEF;
    localparam int SLOTS = RULES_PER_NODE_DEF;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1650;
    localparam int QUIET_TAIL = 250;
    localparam int MAX_SHOWN = 10;

    typedef logic [FIELDS-1:0][TOK_W-1:0] t_tokens;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [NODE_W-1:0] node;
        logic [SLOT_W-1:0] slot;
        t_tokens           tok;
        logic [FIELDS-1:0] any;
        logic [NODE_W-1:0] target;
    } t_tb_cmd;

    typedef struct packed {
        logic [OUT_W-1:0]  outcome;
        logic [NODE_W-1:0] at_node;
    } t_route_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic sink_ready = 1'b0;

    wrw_in_if  in_ch ();
    wrw_out_if out_ch ();

    assign out_ch.ready = sink_ready;

    wildcard_route_walk u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the rule table
    t_tokens           tbl_tok  [NODES*SLOTS];
    logic [FIELDS-1:0] tbl_any  [NODES*SLOTS];
    logic [NODE_W-1:0] tbl_next [NODES*SLOTS];
    int unsigned       tbl_count [NODES];

    t_route_result pending_routes [$];
    logic [TOK_W-1:0] tok_pool [4];

    bit idle_on = 1'b1;
    bit quiet = 1'b0;
    int unsigned items_done = 0;
    int unsigned transfers = 0;
    int unsigned n_delivered = 0;
    int unsigned n_circular = 0;
    int unsigned n_unroutable = 0;
    int unsigned n_checked = 0;
    int unsigned n_errors = 0;
    int unsigned stall_left = 0;

    function automatic t_route_result walk_route(t_tb_cmd c);
        logic [NODES-1:0] seen;
        int unsigned now;
        int unsigned idx;
        int unsigned tgt;
        bit moved;
        bit taken;
        bit hit;
        t_route_result r;
        seen = '0;
        now = c.node;
        moved = 1'b1;
        r.outcome = OUT_UNROUTABLE;
        r.at_node = c.node;
        for (int hop = 0; hop <= NODES && moved; hop++) begin
            seen[now] = 1'b1;
            moved = 1'b0;
            taken = 1'b0;
            r.outcome = OUT_UNROUTABLE;
            r.at_node = now[NODE_W-1:0];
            for (int i = 0; i < tbl_count[now] && !taken; i++) begin
                idx = now * SLOTS + i;
                hit = 1'b1;
                for (int f = 0; f < FIELDS; f++)
                    if (!(c.any[f] || tbl_any[idx][f] || c.tok[f] == tbl_tok[idx][f]))
                        hit = 1'b0;
                if (hit) begin
                    taken = 1'b1;
                    tgt = tbl_next[idx];
                    if (tgt == now) begin
                        r.outcome = OUT_DELIVERED;
                    end else if (seen[tgt]) begin
                        r.outcome = OUT_CIRCULAR;
                        r.at_node = tgt[NODE_W-1:0];
                    end else begin
                        now = tgt;
                        moved = 1'b1;
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic void apply_cmd(t_tb_cmd c);
        int unsigned idx;
        t_route_result r;
        transfers++;
        if (c.opcode != OP_UNUSED)
            items_done++;
        case (c.opcode)
            OP_WRITE_RULE: begin
                if (c.slot < SLOTS) begin
                    idx = c.node * SLOTS + c.slot;
                    tbl_tok[idx] = c.tok;
                    tbl_any[idx] = c.any;
                    tbl_next[idx] = c.target;
                end
            end
            OP_SET_COUNT: begin
                tbl_count[c.node] = (c.slot > SLOTS) ? SLOTS : c.slot;
            end
            OP_ROUTE: begin
                r = walk_route(c);
                pending_routes.push_back(r);
                case (r.outcome)
                    OUT_DELIVERED: n_delivered++;
                    OUT_CIRCULAR:  n_circular++;
                    default:       n_unroutable++;
                endcase
            end
            default: ;
        endcase
    endfunction

    function automatic t_tb_cmd mk_cmd(logic [1:0] op, int unsigned node, int unsigned slot,
                                       t_tokens tok, logic [FIELDS-1:0] any,
                                       int unsigned target);
        t_tb_cmd c;
        c.opcode = op;
        c.node = node[NODE_W-1:0];
        c.slot = slot[SLOT_W-1:0];
        c.tok = tok;
        c.any = any;
        c.target = target[NODE_W-1:0];
        return c;
    endfunction

    // field order: country, admin, private, organization
    function automatic t_tokens toks(logic [TOK_W-1:0] ctry, logic [TOK_W-1:0] adm,
                                     logic [TOK_W-1:0] prv, logic [TOK_W-1:0] org);
        return {org, prv, adm, ctry};
    endfunction

    function automatic t_tokens pick_tokens(int unsigned pool_pct);
        t_tokens t;
        for (int f = 0; f < FIELDS; f++)
            t[f] = ($urandom_range(0, 99) < pool_pct) ? tok_pool[$urandom_range(0, 3)]
                                                     : TOK_W'($urandom);
        return t;
    endfunction

    function automatic logic [FIELDS-1:0] pick_any(int unsigned one_in);
        logic [FIELDS-1:0] a;
        for (int f = 0; f < FIELDS; f++)
            a[f] = ($urandom_range(0, one_in - 1) == 0);
        return a;
    endfunction

    function automatic t_tb_cmd rand_rule();
        t_tb_cmd c;
        c = mk_cmd(OP_WRITE_RULE, $urandom_range(0, NODES - 1), $urandom_range(0, SLOTS - 1),
                   pick_tokens(75), pick_any(4), $urandom_range(0, NODES - 1));
        if ($urandom_range(0, 4) == 0)
            c.target = c.node;
        return c;
    endfunction

    function automatic t_tb_cmd rand_count();
        int unsigned cnt;
        case ($urandom_range(0, 7))
            0:       cnt = $urandom_range(0, SLOTS);
            1:       cnt = $urandom_range(SLOTS + 1, 31);
            default: cnt = $urandom_range(0, 6);
        endcase
        return mk_cmd(OP_SET_COUNT, $urandom_range(0, NODES - 1), cnt, pick_tokens(0),
                      pick_any(2), $urandom_range(0, NODES - 1));
    endfunction

    function automatic t_tb_cmd rand_route();
        return mk_cmd(OP_ROUTE, $urandom_range(0, NODES - 1), $urandom_range(0, 31),
                      pick_tokens(85), pick_any(6), $urandom_range(0, NODES - 1));
    endfunction

    // unused opcode or a rule write to a slot past the table
    function automatic t_tb_cmd rand_noise();
        t_tb_cmd c;
        c = rand_rule();
        if ($urandom_range(0, 1) == 0)
            c.opcode = OP_UNUSED;
        else
            c.slot = SLOT_W'($urandom_range(SLOTS, 31));
        return c;
    endfunction

    task automatic send_cmd(input t_tb_cmd c);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.opcode         <= c.opcode;
        in_ch.node           <= c.node;
        in_ch.slot_or_count  <= c.slot;
        in_ch.country        <= c.tok[0];
        in_ch.admin_domain   <= c.tok[1];
        in_ch.private_domain <= c.tok[2];
        in_ch.organization   <= c.tok[3];
        in_ch.country_any    <= c.any[0];
        in_ch.admin_any      <= c.any[1];
        in_ch.private_any    <= c.any[2];
        in_ch.org_any        <= c.any[3];
        in_ch.target_node    <= c.target;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        apply_cmd(c);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_routes.size() != 0) @(posedge i_clk);
    endtask

    // result side: random stall bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sink_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            sink_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 9);
            sink_ready <= 1'b0;
        end else begin
            sink_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_route_result exp_r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            n_checked++;
            if (pending_routes.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_SHOWN)
                    $display("unexpected result transfer: outcome %0d at node %0d",
                             out_ch.outcome, out_ch.at_node);
            end else begin
                exp_r = pending_routes.pop_front();
                if (out_ch.outcome !== exp_r.outcome || out_ch.at_node !== exp_r.at_node) begin
                    n_errors++;
                    if (n_errors <= MAX_SHOWN)
                        $display({"route mismatch: expected outcome %0d at node %0d,",
                                  " got %0d at node %0d"},
                                 exp_r.outcome, exp_r.at_node, out_ch.outcome, out_ch.at_node);
                end
            end
        end
    end

    task automatic test_reset_routes();
        send_cmd(mk_cmd(OP_ROUTE, 0, 0, toks(16'h0, 16'h0, 16'h0, 16'h0), 4'b0000, 0));
        send_cmd(mk_cmd(OP_ROUTE, 15, 31, toks(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
                        4'b1111, 15));
    endtask

    task automatic test_exact_match();
        send_cmd(mk_cmd(OP_WRITE_RULE, 1, 0, toks(16'hFFFF, 16'h0, 16'hFFFF, 16'h0),
                        4'b0000, 1));
        send_cmd(mk_cmd(OP_SET_COUNT, 1, 1, '0, 4'b0000, 0));
        send_cmd(mk_cmd(OP_ROUTE, 1, 0, toks(16'hFFFF, 16'h0, 16'hFFFF, 16'h0), 4'b0000, 0));
        send_cmd(mk_cmd(OP_ROUTE, 1, 0, toks(16'hFFFF, 16'h0, 16'hFFFF, 16'h1), 4'b0000, 0));
        // message wildcards on every field
        send_cmd(mk_cmd(OP_ROUTE, 1, 0, toks(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0),
                        4'b1111, 0));
    endtask

    task automatic test_loop();
        send_cmd(mk_cmd(OP_WRITE_RULE, 2, 0, '0, 4'b1111, 3));
        send_cmd(mk_cmd(OP_WRITE_RULE, 3, 0, '0, 4'b1111, 2));
        send_cmd(mk_cmd(OP_SET_COUNT, 2, 1, '0, 4'b0000, 0));
        send_cmd(mk_cmd(OP_SET_COUNT, 3, 1, '0, 4'b0000, 0));
        send_cmd(mk_cmd(OP_ROUTE, 2, 0, toks(16'h7, 16'h7, 16'h7, 16'h7), 4'b0000, 0));
        send_cmd(mk_cmd(OP_ROUTE, 3, 0, toks(16'h7, 16'h7, 16'h7, 16'h7), 4'b0000, 0));
    endtask

    task automatic test_first_match();
        send_cmd(mk_cmd(OP_WRITE_RULE, 4, 0, toks(16'h5, 16'h0, 16'h0, 16'h0), 4'b1110, 5));
        send_cmd(mk_cmd(OP_WRITE_RULE, 4, 1, '0, 4'b1111, 4));
        send_cmd(mk_cmd(OP_SET_COUNT, 4, 2, '0, 4'b0000, 0));
        send_cmd(mk_cmd(OP_ROUTE, 4, 0, toks(16'h5, 16'h1, 16'h2, 16'h3), 4'b0000, 0));
        send_cmd(mk_cmd(OP_ROUTE, 4, 0, toks(16'h6, 16'h1, 16'h2, 16'h3), 4'b0000, 0));
    endtask

    // unused opcode, slot past the table, count above the table size
    task automatic test_ignored_writes();
        send_cmd(mk_cmd(OP_UNUSED, 4, 0, toks(16'h6, 16'h1, 16'h2, 16'h3), 4'b1111, 9));
        send_cmd(mk_cmd(OP_WRITE_RULE, 4, SLOTS, '0, 4'b1111, 9));
        send_cmd(mk_cmd(OP_WRITE_RULE, 4, 31, '0, 4'b1111, 9));
        send_cmd(mk_cmd(OP_SET_COUNT, 6, 20, '0, 4'b0000, 0));
        send_cmd(mk_cmd(OP_ROUTE, 4, 0, toks(16'h6, 16'h1, 16'h2, 16'h3), 4'b0000, 0));
    endtask

    // every slot gets written so any later count only covers written rules
    task automatic test_table_fill();
        t_tb_cmd c;
        for (int n = 0; n < NODES; n++)
            for (int s = 0; s < SLOTS; s++) begin
                c = rand_rule();
                c.node = n[NODE_W-1:0];
                c.slot = s[SLOT_W-1:0];
                send_cmd(c);
            end
        for (int n = 0; n < NODES; n++) begin
            c = rand_count();
            c.node = n[NODE_W-1:0];
            send_cmd(c);
        end
    endtask

    task automatic test_drain_pause();
        repeat (12) send_cmd(rand_route());
        drain_results();
        repeat (12) send_cmd(rand_route());
    endtask

    task automatic test_random_phases();
        int unsigned pick;
        while (items_done < RANDOM_ITEMS) begin
            if (items_done > RANDOM_ITEMS - QUIET_TAIL)
                quiet = 1'b1;
            idle_on = !quiet && ($urandom_range(0, 3) != 0);
            tok_pool[$urandom_range(0, 3)] = TOK_W'($urandom);
            repeat ($urandom_range(4, 24)) send_cmd(rand_rule());
            repeat ($urandom_range(1, 6)) send_cmd(rand_count());
            repeat ($urandom_range(15, 40)) begin
                pick = $urandom_range(0, 15);
                if (pick == 0)
                    send_cmd(rand_noise());
                else if (pick <= 2)
                    send_cmd(rand_rule());
                else if (pick == 3)
                    send_cmd(rand_count());
                else
                    send_cmd(rand_route());
            end
        end
    endtask

    initial begin
        in_ch.valid          = 1'b0;
        in_ch.opcode         = OP_WRITE_RULE;
        in_ch.node           = '0;
        in_ch.slot_or_count  = '0;
        in_ch.country        = '0;
        in_ch.admin_domain   = '0;
        in_ch.private_domain = '0;
        in_ch.organization   = '0;
        in_ch.country_any    = 1'b0;
        in_ch.admin_any      = 1'b0;
        in_ch.private_any    = 1'b0;
        in_ch.org_any        = 1'b0;
        in_ch.target_node    = '0;
        for (int n = 0; n < NODES; n++)
            tbl_count[n] = 0;
        for (int p = 0; p < 4; p++)
            tok_pool[p] = TOK_W'($urandom);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_routes();
        test_exact_match();
        test_loop();
        test_first_match();
        test_ignored_writes();
        test_table_fill();
        test_drain_pause();
        test_random_phases();

        drain_results();
        repeat (NODES + 8) @(posedge i_clk);
        $display("Covered %0d transfers in, %0d results checked:", transfers, n_checked);
        $display("  %0d delivered, %0d circular, %0d unroutable",
                 n_delivered, n_circular, n_unroutable);
        $display("Mismatches: %0d", n_errors);
        if (n_errors == 0 && pending_routes.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #5000000;
        $display("Timeout with %0d routes outstanding", pending_routes.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
